[rtl/rc4_pkg.sv]
// Shared constants, microcode types and the control store of the RC4 core.
// Used by the channel interfaces, the top level and the checker.
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = 8;
    localparam int KEY_BYTES  = 16;
    localparam int KEY_IDX_W  = 4;
    localparam int KEY_LEN_W  = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW    = 2'd0,
        CFG_KEY_HIGH   = 2'd1,
        CFG_KEY_LENGTH = 2'd2
    } cfg_index_t;

    // Microprogram step addresses.
    typedef enum logic [STEP_W-1:0] {
        U_IDLE = 4'd0,
        U_FILL = 4'd1,
        U_KA   = 4'd2,
        U_KB   = 4'd3,
        U_KC   = 4'd4,
        U_KD   = 4'd5,
        U_KEND = 4'd6,
        U_P1   = 4'd7,
        U_P2   = 4'd8,
        U_P3   = 4'd9,
        U_P4   = 4'd10,
        U_P5   = 4'd11
    } step_t;

    typedef enum logic [2:0] {
        AS_N      = 3'd0,
        AS_I      = 3'd1,
        AS_J      = 3'd2,
        AS_I_NEXT = 3'd3,
        AS_J_NEXT = 3'd4,
        AS_T      = 3'd5
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_N     = 2'd0,
        WD_RDATA = 2'd1,
        WD_SI    = 2'd2
    } wdata_sel_t;

    typedef enum logic [1:0] {
        J_HOLD  = 2'd0,
        J_CLEAR = 2'd1,
        J_KSA   = 2'd2,
        J_PRGA  = 2'd3
    } j_op_t;

    typedef enum logic [1:0] {
        I_HOLD  = 2'd0,
        I_CLEAR = 2'd1,
        I_INC   = 2'd2
    } i_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD  = 2'd0,
        CNT_CLEAR = 2'd1,
        CNT_INC   = 2'd2
    } cnt_op_t;

    typedef enum logic [1:0] {
        JC_NEXT     = 2'd0,
        JC_LOOP     = 2'd1,
        JC_DISPATCH = 2'd2,
        JC_OUT      = 2'd3
    } jump_t;

    typedef struct packed {
        logic       rd_en;
        addr_sel_t  rd_sel;
        logic       we;
        addr_sel_t  wr_sel;
        wdata_sel_t wd_sel;
        i_op_t      i_op;
        j_op_t      j_op;
        cnt_op_t    n_op;
        cnt_op_t    k_op;
        logic       ld_si;
        logic       ld_sj;
        logic       ld_hit;
        logic       out_ld;
        jump_t      jump;
        step_t      target;
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        rd_en:  1'b0,
        rd_sel: AS_N,
        we:     1'b0,
        wr_sel: AS_N,
        wd_sel: WD_N,
        i_op:   I_HOLD,
        j_op:   J_HOLD,
        n_op:   CNT_HOLD,
        k_op:   CNT_HOLD,
        ld_si:  1'b0,
        ld_sj:  1'b0,
        ld_hit: 1'b0,
        out_ld: 1'b0,
        jump:   JC_NEXT,
        target: U_IDLE
    };

    // Control store. The fill and key-mixing loops run on the counter n and
    // leave their loop when n reaches its last value.
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t cw;
        cw = CW_NOP;
        unique case (step)
            U_IDLE:
            begin
                cw.n_op = CNT_CLEAR;
                cw.k_op = CNT_CLEAR;
                cw.jump = JC_DISPATCH;
            end
            U_FILL:
            begin
                cw.we     = 1'b1;
                cw.wr_sel = AS_N;
                cw.wd_sel = WD_N;
                cw.n_op   = CNT_INC;
                cw.j_op   = J_CLEAR;
                cw.jump   = JC_LOOP;
                cw.target = U_FILL;
            end
            U_KA:
            begin
                cw.rd_en  = 1'b1;
                cw.rd_sel = AS_N;
            end
            U_KB:
            begin
                cw.ld_si  = 1'b1;
                cw.j_op   = J_KSA;
                cw.rd_en  = 1'b1;
                cw.rd_sel = AS_J_NEXT;
            end
            U_KC:
            begin
                cw.we     = 1'b1;
                cw.wr_sel = AS_N;
                cw.wd_sel = WD_RDATA;
            end
            U_KD:
            begin
                cw.we     = 1'b1;
                cw.wr_sel = AS_J;
                cw.wd_sel = WD_SI;
                cw.n_op   = CNT_INC;
                cw.k_op   = CNT_INC;
                cw.jump   = JC_LOOP;
                cw.target = U_KA;
            end
            U_KEND:
            begin
                cw.i_op = I_CLEAR;
                cw.j_op = J_CLEAR;
            end
            U_P1:
            begin
                cw.i_op   = I_INC;
                cw.rd_en  = 1'b1;
                cw.rd_sel = AS_I_NEXT;
            end
            U_P2:
            begin
                cw.ld_si  = 1'b1;
                cw.j_op   = J_PRGA;
                cw.rd_en  = 1'b1;
                cw.rd_sel = AS_J_NEXT;
            end
            U_P3:
            begin
                cw.ld_sj  = 1'b1;
                cw.we     = 1'b1;
                cw.wr_sel = AS_I;
                cw.wd_sel = WD_RDATA;
            end
            U_P4:
            begin
                cw.we     = 1'b1;
                cw.wr_sel = AS_J;
                cw.wd_sel = WD_SI;
                cw.rd_en  = 1'b1;
                cw.rd_sel = AS_T;
                cw.ld_hit = 1'b1;
            end
            U_P5:
            begin
                cw.out_ld = 1'b1;
                cw.jump   = JC_OUT;
                cw.target = U_IDLE;
            end
            default:
            begin
                cw.jump   = JC_OUT;
                cw.target = U_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

[rtl/rc4_in_if.sv]
// Input channel of the RC4 core: one data byte and a start-of-message flag.
// Depends on rc4_pkg for the byte width.
interface rc4_in_if import rc4_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_in;
    logic              start_req;

    modport source (output valid, output data_in, output start_req, input ready);
    modport sink   (input valid, input data_in, input start_req, output ready);
endinterface

[rtl/rc4_out_if.sv]
// Output channel of the RC4 core: one transformed byte per item.
// Depends on rc4_pkg for the byte width.
interface rc4_out_if import rc4_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

[rtl/rc4_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the old contents. No dependencies.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/rc4_stream_cipher_core.sv]
// RC4 stream cipher core: microcoded sequencer, S-box RAM and key registers.
// Depends on rc4_pkg, rc4_in_if, rc4_out_if and rc4_ram.
//
// Usage: each item on in_ch carries one byte and a start flag; each item
// gives exactly one byte on out_ch, the input XOR the next keystream byte.
// Set start_req on the first byte of every message; the key schedule then
// runs from the key registers before that byte is transformed.
// The key is written through cfg_we/cfg_index/cfg_data while the core is idle:
// index 0 holds key bytes 0..7, index 1 bytes 8..15, index 2 the key length.
// Sequence: an item without start runs the steps U_P1 to U_P5 after it is accepted,
// and in_ch.ready rises with the same edge that registers the result, so a
// new item is taken only once the last one's result is registered. With start
// the fill pass over all 256 entries, the key mixing (steps U_KA to U_KD for
// each entry) and one clearing step come first. The single S-box RAM port pair
// and the swap that each keystream byte needs make these steps run in turn.
// Reset returns the sequencer to idle, clears i and j, the output valid and
// the key registers (key length 16); the S-box is undefined until the first
// start. When out_ch stalls, the result waits in the output register and the
// next item is still accepted; its result waits in the last step until the
// output register is free.
module rc4_stream_cipher_core import rc4_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    rc4_in_if.sink                in_ch,
    rc4_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    step_t      step_reg, step_next;
    ctrl_word_t cw;

    logic [SBOX_AW-1:0]   i_reg, i_next;
    logic [SBOX_AW-1:0]   j_reg, j_next;
    logic [SBOX_AW-1:0]   n_reg, n_next;
    logic [KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [BYTE_W-1:0]    si_reg, sj_reg, data_reg;
    logic                 hit_reg;
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_data_reg;

    logic [CFG_DATA_W-1:0] key_low_reg, key_high_reg;
    logic [KEY_LEN_W-1:0]  key_length_reg;

    logic                 in_accept, out_free, out_load;
    logic [CFG_DATA_W-1:0] key_word;
    logic [BYTE_W-1:0]    key_byte;
    logic [KEY_IDX_W-1:0] key_last;
    logic [SBOX_AW-1:0]   t_addr;
    logic [BYTE_W-1:0]    keystream;

    logic                 ram_we, ram_re;
    logic [SBOX_AW-1:0]   ram_waddr, ram_raddr;
    logic [BYTE_W-1:0]    ram_wdata, ram_rdata;

    function automatic logic [SBOX_AW-1:0] pick_addr(
        input addr_sel_t          sel,
        input logic [SBOX_AW-1:0] n,
        input logic [SBOX_AW-1:0] i,
        input logic [SBOX_AW-1:0] j,
        input logic [SBOX_AW-1:0] i_nx,
        input logic [SBOX_AW-1:0] j_nx,
        input logic [SBOX_AW-1:0] t
    );
        logic [SBOX_AW-1:0] a;
        unique case (sel)
            AS_N:      a = n;
            AS_I:      a = i;
            AS_J:      a = j;
            AS_I_NEXT: a = i_nx;
            AS_J_NEXT: a = j_nx;
            AS_T:      a = t;
            default:   a = n;
        endcase
        return a;
    endfunction

    assign cw        = ucode_rom(step_reg);
    assign in_ch.ready = (step_reg == U_IDLE);
    assign in_accept = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign out_load  = cw.out_ld && out_free;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.data_out = out_data_reg;

    // Sequencer: next step address.
    always_comb
    begin
        step_next = step_reg;
        unique case (cw.jump)
            JC_NEXT:
            begin
                step_next = step_t'(step_reg + STEP_W'(1));
            end
            JC_LOOP:
            begin
                if (n_reg != '1)
                begin
                    step_next = cw.target;
                end
                else
                begin
                    step_next = step_t'(step_reg + STEP_W'(1));
                end
            end
            JC_DISPATCH:
            begin
                if (in_accept)
                begin
                    step_next = in_ch.start_req ? U_FILL : U_P1;
                end
            end
            JC_OUT:
            begin
                if (out_free)
                begin
                    step_next = cw.target;
                end
            end
            default:
            begin
                step_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= U_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Key byte for the mixing loop, taken cyclically over the key length.
    assign key_word = kidx_reg[KEY_IDX_W-1] ? key_high_reg : key_low_reg;
    assign key_byte = key_word[{kidx_reg[KEY_IDX_W-2:0], 3'b000} +: BYTE_W];

    always_comb
    begin
        if (key_length_reg == '0)
        begin
            key_last = '0;
        end
        else if (key_length_reg > KEY_LEN_W'(KEY_BYTES))
        begin
            key_last = KEY_IDX_W'(KEY_BYTES - 1);
        end
        else
        begin
            key_last = KEY_IDX_W'(key_length_reg - KEY_LEN_W'(1));
        end
    end

    // Datapath next values.
    always_comb
    begin
        unique case (cw.i_op)
            I_HOLD:  i_next = i_reg;
            I_CLEAR: i_next = '0;
            I_INC:   i_next = i_reg + SBOX_AW'(1);
            default: i_next = i_reg;
        endcase

        unique case (cw.j_op)
            J_HOLD:  j_next = j_reg;
            J_CLEAR: j_next = '0;
            J_KSA:   j_next = j_reg + ram_rdata + key_byte;
            J_PRGA:  j_next = j_reg + ram_rdata;
            default: j_next = j_reg;
        endcase

        unique case (cw.n_op)
            CNT_HOLD:  n_next = n_reg;
            CNT_CLEAR: n_next = '0;
            CNT_INC:   n_next = n_reg + SBOX_AW'(1);
            default:   n_next = n_reg;
        endcase

        unique case (cw.k_op)
            CNT_HOLD:  kidx_next = kidx_reg;
            CNT_CLEAR: kidx_next = '0;
            CNT_INC:   kidx_next = (kidx_reg == key_last) ? '0 : kidx_reg + KEY_IDX_W'(1);
            default:   kidx_next = kidx_reg;
        endcase
    end

    assign t_addr = si_reg + sj_reg;

    assign ram_we    = cw.we;
    assign ram_re    = cw.rd_en;
    assign ram_waddr = pick_addr(cw.wr_sel, n_reg, i_reg, j_reg, i_next, j_next, t_addr);
    assign ram_raddr = pick_addr(cw.rd_sel, n_reg, i_reg, j_reg, i_next, j_next, t_addr);

    always_comb
    begin
        unique case (cw.wd_sel)
            WD_N:     ram_wdata = n_reg;
            WD_RDATA: ram_wdata = ram_rdata;
            WD_SI:    ram_wdata = si_reg;
            default:  ram_wdata = n_reg;
        endcase
    end

    // The keystream read shares its cycle with the write of S[j]; the RAM then
    // returns the old entry, so a read of j takes the swapped value instead.
    assign keystream = hit_reg ? si_reg : ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg    <= i_next;
            j_reg    <= j_next;
            n_reg    <= n_next;
            kidx_reg <= kidx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_reg <= in_ch.data_in;
        end
        if (cw.ld_si)
        begin
            si_reg <= ram_rdata;
        end
        if (cw.ld_sj)
        begin
            sj_reg <= ram_rdata;
        end
        if (cw.ld_hit)
        begin
            hit_reg <= (t_addr == j_reg);
        end
        if (out_load)
        begin
            out_data_reg <= data_reg ^ keystream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= KEY_LEN_W'(KEY_BYTES);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                CFG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH),
        .AW    (SBOX_AW)
    ) u_sbox (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[rtl/rc4_checker.sv]
// Port-level assertions for the RC4 core and the bind that attaches them.
// Depends on rc4_pkg and rc4_stream_cipher_core.
module rc4_checker import rc4_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] data_out
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out))
        else $error("result changed while stalled");

    // Every item keeps the core busy, with in_ready low, at least through U_P1 to U_P5.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready
            ##1 !in_ready)
        else $error("core ready again too early after an item");

    // A new result is only produced while an item is being worked on.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the core was idle");

    // Reset holds the output channel empty.
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind rc4_stream_cipher_core rc4_checker u_rc4_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .data_out  (out_ch.data_out)
);

[bench/rc4_stream_cipher_core_tb.sv]
// Self-checking bench for rc4_stream_cipher_core: every output byte is predicted and compared.
// Uses rc4_pkg, rc4_in_if, rc4_out_if and the core itself from the RTL tree.
module rc4_stream_cipher_core_tb import rc4_pkg::*; ;

    localparam int STALL_LIMIT   = 6000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 530;
    // Index 3 has no register behind it; writes to it must leave the key alone.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    // Software copy of the cipher: key registers, S-box, indices and the bytes
    // still owed by the core.
    class cipher_tracker;
        logic [BYTE_W-1:0]     perm [SBOX_DEPTH];
        logic [BYTE_W-1:0]     idx_i;
        logic [BYTE_W-1:0]     idx_j;
        logic [CFG_DATA_W-1:0] key_low;
        logic [CFG_DATA_W-1:0] key_high;
        logic [KEY_LEN_W-1:0]  key_len;
        logic [BYTE_W-1:0]     expected_bytes [$];
        int                    errors;
        int                    bytes_checked;
        int                    schedules;

        function new();
            key_low       = '0;
            key_high      = '0;
            key_len       = KEY_LEN_W'(KEY_BYTES);
            idx_i         = '0;
            idx_j         = '0;
            errors        = 0;
            bytes_checked = 0;
            schedules     = 0;
            foreach (perm[n])
                perm[n] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_KEY_LOW:    key_low  = value;
                CFG_KEY_HIGH:   key_high = value;
                CFG_KEY_LENGTH: key_len  = value[KEY_LEN_W-1:0];
                default:        ;
            endcase
        endfunction

        function void run_key_schedule();
            int unsigned       len;
            int unsigned       k;
            logic [BYTE_W-1:0] j;
            logic [BYTE_W-1:0] t;
            logic [BYTE_W-1:0] kb;
            len = key_len;
            // A zero length uses one key byte; anything past the key size saturates.
            if (len == 0)
                len = 1;
            if (len > KEY_BYTES)
                len = KEY_BYTES;
            for (int n = 0; n < SBOX_DEPTH; n++)
                perm[n] = BYTE_W'(n);
            j = '0;
            for (int n = 0; n < SBOX_DEPTH; n++)
            begin
                k = n % len;
                if (k < 8)
                    kb = key_low[BYTE_W*k +: BYTE_W];
                else
                    kb = key_high[BYTE_W*(k-8) +: BYTE_W];
                j       = j + perm[n] + kb;
                t       = perm[n];
                perm[n] = perm[j];
                perm[j] = t;
            end
            idx_i = '0;
            idx_j = '0;
            schedules++;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] data, logic start);
            logic [BYTE_W-1:0] t;
            if (start)
                run_key_schedule();
            idx_i       = idx_i + 1'b1;
            idx_j       = idx_j + perm[idx_i];
            t           = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            t           = perm[idx_i] + perm[idx_j];
            expected_bytes.push_back(data ^ perm[t]);
        endfunction

        function void check_byte(logic [BYTE_W-1:0] actual);
            logic [BYTE_W-1:0] want;
            if (expected_bytes.size() == 0)
            begin
                $error("data_out: item with no expected byte, actual %02h", actual);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (actual !== want)
            begin
                $error("data_out mismatch: expected %02h, actual %02h", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    stall_cycles;
    int                    reg_writes;
    int                    key_settings;
    cipher_tracker         tracker = new();

    rc4_in_if  in_ch ();
    rc4_out_if out_ch ();

    rc4_stream_cipher_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Entered and left at a falling edge; valid stays high for a following item.
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic start);
        in_ch.valid     <= 1'b1;
        in_ch.data_in   <= data;
        in_ch.start_req <= start;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        tracker.note_byte(data, start);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Stops sending and waits until the core has delivered everything it owes.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.set_reg(idx, value);
        reg_writes++;
        @(negedge clk);
    endtask

    // Receiver: segments of free flow, random stalls and long stalls.
    initial
    begin
        int unsigned mode;
        int unsigned span;
        out_ch.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(16, 160);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 1) == 0);
                    default: out_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            tracker.check_byte(out_ch.data_out);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int unsigned          random_items;
        int unsigned          items;
        int unsigned          burst;
        int unsigned          gap;
        logic                 first;
        logic [KEY_LEN_W-1:0] len;
        logic [CFG_DATA_W-1:0] word;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_in   = '0;
        in_ch.start_req = 1'b0;
        stall_cycles    = 0;
        reg_writes      = 0;
        key_settings    = 1;
        random_items    = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset key: all zero bytes, full length.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        drain();

        // All-ones key at the longest length.
        write_reg(CFG_KEY_LOW, '1);
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(KEY_BYTES));
        key_settings++;
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();

        // Single key byte, with zero bytes inside the message.
        write_reg(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_KEY_LENGTH, 64'd1);
        key_settings++;
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();

        // A zero length behaves as one byte.
        write_reg(CFG_KEY_LENGTH, 64'd0);
        key_settings++;
        send_byte(8'h5A, 1'b1);
        send_byte(8'h00, 1'b0);
        drain();

        // Lengths past the key size saturate.
        write_reg(CFG_KEY_LENGTH, 64'd31);
        key_settings++;
        send_byte(8'h3C, 1'b1);
        send_byte(8'h00, 1'b0);
        drain();
        write_reg(CFG_KEY_LENGTH, 64'd17);
        key_settings++;
        send_byte(8'h81, 1'b1);
        drain();

        // A write to the unused index changes nothing; then two starts in a row.
        write_reg(CFG_NO_REG, {$urandom, $urandom});
        send_byte(8'h7E, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b1);

        while (random_items < RANDOM_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 5))
                0:       len = '0;
                1:       len = 5'd1;
                2:       len = KEY_LEN_W'(KEY_BYTES);
                3:       len = KEY_LEN_W'($urandom_range(KEY_BYTES + 1, 31));
                default: len = KEY_LEN_W'($urandom_range(1, KEY_BYTES));
            endcase
            for (int r = 0; r < 2; r++)
            begin
                case ($urandom_range(0, 5))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = {$urandom, $urandom};
                endcase
                if ($urandom_range(0, 3) != 0)
                    write_reg(r == 0 ? CFG_KEY_LOW : CFG_KEY_HIGH, word);
            end
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(len));
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_NO_REG, {$urandom, $urandom});
            key_settings++;

            // Most rounds open a new message; the rest carry on the old stream.
            items = $urandom_range(40, 80);
            if (items > RANDOM_ITEMS - random_items)
                items = RANDOM_ITEMS - random_items;
            first = ($urandom_range(0, 7) != 0);
            while (items > 0)
            begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && items > 0)
                begin
                    send_byte(BYTE_W'($urandom_range(0, 255)),
                              first || ($urandom_range(0, 31) == 0));
                    first = 1'b0;
                    burst--;
                    items--;
                    random_items++;
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0)
                    pause_sender(gap);
            end
        end
        drain();

        $display("Checked %0d output bytes across %0d key schedules,", tracker.bytes_checked,
                 tracker.schedules);
        $display("with %0d register writes over %0d key settings.", reg_writes, key_settings);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
